FILE: rtl/core/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked implication check, disabled during reset
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// clocked next-cycle implication check, disabled during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/fhs_pkg.sv
// package: constants, controller command and status types, float compare
package fhs_pkg;

    localparam int MaxItemsDefault = 64;

    typedef struct packed {
        logic load;       // write input word at count
        logic drop;       // set dropped flag
        logic rd_node;    // read mem[node]
        logic rd_left;    // read mem[left]
        logic rd_right;   // read mem[right]
        logic cap_node;   // latch node data
        logic cap_left;   // latch left data and pick
        logic cap_right;  // latch right data and pick
        logic wr_node;    // mem[node] <= best
        logic wr_top;     // mem[top] <= node data
        logic step_down;  // node <= top
        logic init_build; // node <= n/2-1, size <= n
        logic next_build; // bidx--, node <= bidx - 2
        logic rd_root;    // read mem[0]
        logic rd_end;     // read mem[size-1]
        logic cap_root;
        logic wr_root;    // mem[0] <= end data
        logic wr_end;     // mem[size-1] <= root data, size--, node <= 0
        logic rd_out;     // read mem[out_idx]
        logic cap_out;    // output register load
        logic out_next;   // out_idx++
        logic clear;      // count, dropped reset
    } t_cmd;

    typedef struct packed {
        logic child_in;   // left child exists
        logic right_in;   // right child exists
        logic moved;      // best differs from node
        logic build_done; // build index at zero
        logic size_le1;   // heap size at most one
        logic out_last;   // out_idx is last element
        logic full;       // store full
    } t_sts;

    function automatic logic [31:0] order_key(input logic [31:0] x);
        logic [31:0] k;
        if (x[30:0] == 31'd0) k = 32'h8000_0000;
        else if (x[31]) k = ~x;
        else k = x | 32'h8000_0000;
        return k;
    endfunction

    function automatic logic is_nan(input logic [31:0] x);
        return (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
    endfunction

    function automatic logic float_gt(input logic [31:0] a, input logic [31:0] b);
        return !is_nan(a) && !is_nan(b) && (order_key(a) > order_key(b));
    endfunction

endpackage

FILE: rtl/core/fhs_ctrl.sv
// controller state machine for the heap sort
module fhs_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic          i_last,
    output logic          o_ready,
    output logic          o_valid,
    input  logic          i_ready,
    input  fhs_pkg::t_sts i_sts,
    output fhs_pkg::t_cmd o_cmd
);
    import fhs_pkg::*;

    localparam logic [3:0] S_LOAD = 4'd0, S_BSTART = 4'd1, S_RDN = 4'd2,
        S_RDL = 4'd3, S_RDR = 4'd4, S_PICK = 4'd5, S_SWAP = 4'd6,
        S_XRD0 = 4'd7, S_XRD1 = 4'd8, S_XWR = 4'd9, S_ORD = 4'd10,
        S_OCAP = 4'd11, S_OUT = 4'd12, S_RDW = 4'd13, S_XWE = 4'd14;

    logic [3:0] r_state, n_state;
    logic       r_build, n_build;

    assign o_ready = (r_state == S_LOAD);
    assign o_valid = (r_state == S_OUT);

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        n_build = r_build;
        case (r_state)
            S_LOAD: begin
                if (i_valid) begin
                    o_cmd.load = !i_sts.full;
                    o_cmd.drop = i_sts.full;
                    if (i_last) n_state = S_BSTART;
                end
            end
            S_BSTART: begin
                o_cmd.init_build = 1'b1;
                n_build = 1'b1;
                n_state = S_RDN;
            end
            S_RDN: begin
                if (r_build && i_sts.build_done) begin
                    n_build = 1'b0;
                    n_state = S_XRD0;
                end else begin
                    o_cmd.rd_node = 1'b1;
                    n_state = S_RDW;
                end
            end
            S_RDW: begin
                o_cmd.cap_node = 1'b1;
                if (i_sts.child_in) begin
                    o_cmd.rd_left = 1'b1;
                    n_state = S_RDL;
                end else n_state = S_SWAP;
            end
            S_RDL: begin
                o_cmd.cap_left = 1'b1;
                if (i_sts.right_in) begin
                    o_cmd.rd_right = 1'b1;
                    n_state = S_RDR;
                end else n_state = S_PICK;
            end
            S_RDR: begin
                o_cmd.cap_right = 1'b1;
                n_state = S_PICK;
            end
            S_PICK: begin
                if (i_sts.moved) begin
                    o_cmd.wr_node = 1'b1;
                    n_state = S_SWAP;
                end else n_state = S_SWAP;
            end
            S_SWAP: begin
                if (i_sts.moved) begin
                    o_cmd.wr_top    = 1'b1;
                    o_cmd.step_down = 1'b1;
                    n_state = S_RDN;
                end else if (r_build) begin
                    o_cmd.next_build = 1'b1;
                    n_state = S_RDN;
                end else n_state = S_XRD0;
            end
            S_XRD0: begin
                if (i_sts.size_le1) n_state = S_ORD;
                else begin
                    o_cmd.rd_root = 1'b1;
                    n_state = S_XRD1;
                end
            end
            S_XRD1: begin
                o_cmd.cap_root = 1'b1;
                o_cmd.rd_end   = 1'b1;
                n_state = S_XWR;
            end
            S_XWR: begin
                o_cmd.wr_root = 1'b1;
                n_state = S_XWE;
            end
            S_XWE: begin
                o_cmd.wr_end = 1'b1;
                n_state = S_RDN;
            end
            S_ORD: begin
                o_cmd.rd_out = 1'b1;
                n_state = S_OCAP;
            end
            S_OCAP: begin
                o_cmd.cap_out = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_ready) begin
                    if (i_sts.out_last) begin
                        o_cmd.clear = 1'b1;
                        n_state = S_LOAD;
                    end else begin
                        o_cmd.out_next = 1'b1;
                        n_state = S_ORD;
                    end
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_build <= 1'b0;
        end else begin
            r_state <= n_state;
            r_build <= n_build;
        end
    end

    `include "assert_macros.svh"
    `ASSERT_IMP(a_one_side, i_clk, i_rst_n, 1'b1, !(o_ready && o_valid), "both sides open")
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid, "result withdrawn")
    `ASSERT_IMP(a_no_load_full, i_clk, i_rst_n, o_cmd.load, !i_sts.full, "write to full store")
endmodule

FILE: rtl/core/fhs_dp.sv
// datapath: element store, heap pointers, compare, output register
module fhs_dp #(
    parameter int MAX_ITEMS = fhs_pkg::MaxItemsDefault
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [31:0]   i_value,
    input  fhs_pkg::t_cmd i_cmd,
    output fhs_pkg::t_sts o_sts,
    output logic [31:0]   o_sorted_value,
    output logic          o_last_out,
    output logic          o_overflow
);
    import fhs_pkg::*;

    localparam int AW = $clog2(MAX_ITEMS);
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int XW = AW + 2;

    logic [31:0] r_mem [MAX_ITEMS];
    logic [31:0] r_rd;
    logic [CW-1:0] r_count;
    logic r_dropped;
    logic [XW-1:0] r_node, r_top, r_size, r_bidx, r_oidx;
    logic [31:0] r_nd, r_best;

    logic [XW-1:0] w_left, w_right, w_addr, w_waddr, w_n;
    logic [31:0] w_wdata;
    logic w_we;
    logic [4:0] w_wr_sel;

    assign w_n      = XW'(r_count);
    assign w_left   = {r_node[XW-2:0], 1'b1};
    assign w_right  = w_left + XW'(1);
    assign w_wr_sel = {i_cmd.load, i_cmd.wr_node, i_cmd.wr_top, i_cmd.wr_root, i_cmd.wr_end};

    always_comb begin
        w_addr = r_node;
        if (i_cmd.rd_node) w_addr = r_node;
        else if (i_cmd.rd_left) w_addr = w_left;
        else if (i_cmd.rd_right) w_addr = w_right;
        else if (i_cmd.rd_root) w_addr = '0;
        else if (i_cmd.rd_end) w_addr = r_size - XW'(1);
        else if (i_cmd.rd_out) w_addr = r_oidx;
        w_we = 1'b1;
        w_waddr = r_node;
        w_wdata = r_best;
        if (i_cmd.load) begin
            w_waddr = XW'(r_count);
            w_wdata = i_value;
        end else if (i_cmd.wr_node) begin
            w_waddr = r_node;
            w_wdata = r_best;
        end else if (i_cmd.wr_top) begin
            w_waddr = r_top;
            w_wdata = r_nd;
        end else if (i_cmd.wr_root) begin
            w_waddr = '0;
            w_wdata = r_rd;
        end else if (i_cmd.wr_end) begin
            w_waddr = r_size - XW'(1);
            w_wdata = r_nd;
        end else w_we = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_waddr[AW-1:0]] <= w_wdata;
        r_rd <= r_mem[w_addr[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_dropped <= 1'b0;
        end else begin
            if (i_cmd.load) r_count <= r_count + CW'(1);
            if (i_cmd.drop) r_dropped <= 1'b1;
            if (i_cmd.clear) begin
                r_count   <= '0;
                r_dropped <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.init_build) begin
            r_size <= w_n;
            r_bidx <= w_n >> 1;
            r_node <= (w_n >> 1) - XW'(1);
            r_oidx <= '0;
        end
        if (i_cmd.next_build) begin
            r_bidx <= r_bidx - XW'(1);
            r_node <= r_bidx - XW'(2);
        end
        if (i_cmd.cap_node) begin
            r_nd   <= r_rd;
            r_best <= r_rd;
            r_top  <= r_node;
        end
        if (i_cmd.cap_left && float_gt(r_rd, r_best)) begin
            r_best <= r_rd;
            r_top  <= w_left;
        end
        if (i_cmd.cap_right && float_gt(r_rd, r_best)) begin
            r_best <= r_rd;
            r_top  <= w_right;
        end
        if (i_cmd.step_down) r_node <= r_top;
        if (i_cmd.cap_root) r_nd <= r_rd;
        if (i_cmd.wr_end) begin
            r_size <= r_size - XW'(1);
            r_node <= '0;
        end
        if (i_cmd.out_next) r_oidx <= r_oidx + XW'(1);
        if (i_cmd.cap_out) begin
            o_sorted_value <= r_rd;
            o_last_out     <= (r_oidx + XW'(1) == w_n);
            o_overflow     <= r_dropped;
        end
    end

    assign o_sts.child_in   = (w_left < r_size);
    assign o_sts.right_in   = (w_right < r_size);
    assign o_sts.moved      = (r_top != r_node);
    assign o_sts.build_done = (r_bidx == '0);
    assign o_sts.size_le1   = (r_size <= XW'(1));
    assign o_sts.out_last   = (r_oidx + XW'(1) == w_n);
    assign o_sts.full       = (r_count == CW'(MAX_ITEMS));

    `include "assert_macros.svh"
    `ASSERT_IMP(a_count_max, i_clk, i_rst_n, 1'b1, r_count <= CW'(MAX_ITEMS), "count overrun")
    `ASSERT_IMP(a_one_write, i_clk, i_rst_n, 1'b1, $onehot0(w_wr_sel), "two writes")
endmodule

FILE: rtl/core/float_heap_sort.sv
// top level: heap sort of single-precision words
// load: one word per cycle while in the load state; after the last word,
// the store is built into a max-heap and sorted in place by root swaps and sift-downs,
// then each sorted word is read, captured in the output register and held until taken
// one set at a time: no input word is taken while a set is sorted or emitted
// reset clears count, overflow flag and controller; store contents are not cleared
module float_heap_sort #(
    parameter int MAX_ITEMS = fhs_pkg::MaxItemsDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_value,
    input  logic        i_last,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_sorted_value,
    output logic        o_last_out,
    output logic        o_overflow
);
    import fhs_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    fhs_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .i_last, .o_ready, .o_valid, .i_ready,
        .i_sts(w_sts), .o_cmd(w_cmd)
    );

    fhs_dp #(.MAX_ITEMS(MAX_ITEMS)) u_dp (
        .i_clk, .i_rst_n, .i_value, .i_cmd(w_cmd), .o_sts(w_sts),
        .o_sorted_value, .o_last_out, .o_overflow
    );
endmodule

FILE: test/float_heap_sort_checker.sv
// checker: predicts sorted output sets of the heap sort and compares them
`timescale 1ns / 100ps
module float_heap_sort_checker #(
    parameter int MAX_ITEMS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_ready_in,
    input  logic [31:0] i_value,
    input  logic        i_last,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [31:0] i_sorted_value,
    input  logic        i_last_out,
    input  logic        i_overflow,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic [31:0] value;
        logic        last_out;
        logic        overflow;
    } t_sorted;

    logic [31:0] held[$];
    logic        dropped;
    t_sorted     sorted_q[$];
    int          fail_count;

    assign o_fail_count = fail_count;
    assign o_pending = sorted_q.size();

    function automatic logic [31:0] rank_key(input logic [31:0] x);
        if (x[30:0] == 31'd0) return 32'h8000_0000;
        if (x[31]) return ~x;
        return x | 32'h8000_0000;
    endfunction

    function automatic logic nan_bits(input logic [31:0] x);
        return (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
    endfunction

    function automatic logic greater(input logic [31:0] a, input logic [31:0] b);
        return !nan_bits(a) && !nan_bits(b) && (rank_key(a) > rank_key(b));
    endfunction

    task automatic sift(inout logic [31:0] h[$], input int node, input int size);
        int top;
        int lc;
        int rc;
        logic [31:0] t;
        forever begin
            top = node;
            lc = 2 * node + 1;
            rc = 2 * node + 2;
            if (lc < size && greater(h[lc], h[top])) top = lc;
            if (rc < size && greater(h[rc], h[top])) top = rc;
            if (top == node) return;
            t = h[node];
            h[node] = h[top];
            h[top] = t;
            node = top;
        end
    endtask

    task automatic emit_sorted_set();
        logic [31:0] h[$];
        logic [31:0] t;
        int n;
        t_sorted s;
        h = held;
        n = h.size();
        for (int i = n / 2; i > 0; i--) sift(h, i - 1, n);
        for (int i = n; i > 1; i--) begin
            t = h[0];
            h[0] = h[i - 1];
            h[i - 1] = t;
            sift(h, 0, i - 1);
        end
        for (int k = 0; k < n; k++) begin
            s.value = h[k];
            s.last_out = (k + 1 == n);
            s.overflow = dropped;
            sorted_q.push_back(s);
        end
        held.delete();
        dropped = 1'b0;
    endtask

    always @(posedge i_clk) begin
        t_sorted want;
        if (!i_rst_n) begin
            held.delete();
            dropped = 1'b0;
            sorted_q.delete();
            fail_count <= 0;
        end else begin
            if (i_valid && i_ready_in) begin
                if (held.size() < MAX_ITEMS) held.push_back(i_value);
                else dropped = 1'b1;
                if (i_last) emit_sorted_set();
            end
            if (i_out_valid && i_out_ready) begin
                if (sorted_q.size() == 0) begin
                    fail_count <= fail_count + 1;
                    if (fail_count < 10)
                        $display("unexpected word %h last %b ovf %b",
                                 i_sorted_value, i_last_out, i_overflow);
                end else begin
                    want = sorted_q.pop_front();
                    if (want.value !== i_sorted_value || want.last_out !== i_last_out
                            || want.overflow !== i_overflow) begin
                        fail_count <= fail_count + 1;
                        if (fail_count < 10)
                            $display("mismatch exp %h/%b/%b got %h/%b/%b",
                                     want.value, want.last_out, want.overflow,
                                     i_sorted_value, i_last_out, i_overflow);
                    end
                end
            end
        end
    end

endmodule

FILE: test/testbench.sv
// testbench top: stimulus for the float heap sort and the final verdict
`timescale 1ns / 100ps
module testbench;

    localparam int MaxItems = fhs_pkg::MaxItemsDefault;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [31:0] i_value = 32'd0;
    logic        i_last = 1'b0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [31:0] o_sorted_value;
    logic        o_last_out;
    logic        o_overflow;
    int          fail_count;
    int          pending;
    logic        calm = 1'b0;
    logic        hold_off = 1'b0;
    int          word_total = 0;
    int          set_len;

    always #2 i_clk = ~i_clk;

    float_heap_sort #(.MAX_ITEMS(MaxItems)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_value(i_value), .i_last(i_last), .o_valid(o_valid), .i_ready(i_ready),
        .o_sorted_value(o_sorted_value), .o_last_out(o_last_out), .o_overflow(o_overflow)
    );

    float_heap_sort_checker #(.MAX_ITEMS(MaxItems)) u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_ready_in(o_ready),
        .i_value(i_value), .i_last(i_last), .i_out_valid(o_valid), .i_out_ready(i_ready),
        .i_sorted_value(o_sorted_value), .i_last_out(o_last_out), .i_overflow(o_overflow),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    function automatic logic [31:0] rand_float();
        logic [31:0] v;
        case ($urandom_range(0, 5))
            0: v = {$urandom_range(0, 1) == 1, 31'd0};
            1: v = {$urandom_range(0, 1) == 1, 8'hFF, 23'd0};
            2: v = {$urandom_range(0, 1) == 1, 8'd0, 23'($urandom)};
            3: v = {$urandom_range(0, 1) == 1, 8'd127, 23'($urandom_range(0, 3))};
            default: v = $urandom;
        endcase
        if (v[30:23] == 8'hFF && v[22:0] != 0) v[22:0] = 23'd0;
        return v;
    endfunction

    task automatic send_word(input logic [31:0] v, input logic l);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 3);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_value <= v;
        i_last <= l;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        word_total++;
    endtask

    task automatic send_set(input int n, input logic directed_edges);
        logic [31:0] edges[12];
        edges = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
                  32'h7F7F_FFFF, 32'hFF7F_FFFF, 32'h0000_0001, 32'h8000_0001,
                  32'h3F80_0000, 32'hBF80_0000, 32'hFFFF_FFFF & 32'hFF7F_FFFF,
                  32'h3F80_0000};
        for (int i = 0; i < n; i++)
            send_word(directed_edges ? edges[i % 12] : rand_float(), i == n - 1);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) i_ready <= 1'b0;
        else if (hold_off) i_ready <= 1'b0;
        else if (calm) i_ready <= 1'b1;
        else i_ready <= ($urandom_range(0, 3) != 0);
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_set(1, 1'b1);
        send_set(12, 1'b1);
        send_set(2, 1'b0);
        send_set(MaxItems + 3, 1'b0);
        fork
            begin
                while (!o_valid) @(posedge i_clk);
                hold_off <= 1'b1;
                repeat (300) @(posedge i_clk);
                hold_off <= 1'b0;
            end
            send_set(5, 1'b0);
        join
        while (word_total < 143) begin
            set_len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, MaxItems)
                                                  : $urandom_range(1, 8);
            if (word_total + set_len > 143) set_len = 143 - word_total;
            send_set(set_len, 1'b0);
        end
        calm <= 1'b1;
        send_set(MaxItems, 1'b0);
        send_set(3, 1'b0);
        i_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (fail_count == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
    end

    initial begin
        #4000000;
        $display("status: fail");
        $finish;
    end

endmodule
